### rtl/qwtg_pkg.sv
package qwtg_pkg;

    localparam int TABLE_DEPTH_DEF    = 32;
    localparam int SQUARE_OUTPUTS_DEF = 4;

    localparam int IDX_W    = 5;
    localparam int TICK_W   = 7;
    localparam int LEN_W    = 6;
    localparam int GAIN_W   = 4;
    localparam int LEVEL_W  = 8;
    localparam int AMP_W    = 4;
    localparam int SQ_MAX   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SQ_PERIOD    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SQ_THRESH    = 3'd7;

    // reset values
    localparam logic             RST_WAVE_MODE = 1'b0;
    localparam logic [LEN_W-1:0] RST_TABLE_LENGTH = 6'd6;
    localparam logic [63:0]      RST_TABLE_LOW = 64'h0000_0000_00A9_8630;
    localparam logic [63:0]      RST_TABLE_HIGH = 64'h0;
    localparam logic [GAIN_W-1:0] RST_GAIN = 4'd5;
    localparam logic [LEVEL_W-1:0] RST_CENTER = 8'd127;
    localparam logic [TICK_W-1:0] RST_SQ_PERIOD = 7'd10;
    localparam logic [27:0]      RST_SQ_THRESH = {7'd8, 7'd5, 7'd2, 7'd1};

    localparam logic MODE_SYMMETRIC = 1'b0;
    localparam logic MODE_CYCLIC    = 1'b1;

    typedef struct packed {
        logic                wave_mode;
        logic [LEN_W-1:0]    table_length;
        logic [127:0]        table_words;   // entry 0 in lowest nibble
        logic [GAIN_W-1:0]   gain;
        logic [LEVEL_W-1:0]  center_offset;
        logic [TICK_W-1:0]   square_period;
        logic [27:0]         square_thresholds;
    } t_cfg;

    typedef struct packed {
        logic [TICK_W-1:0] tick_count;
        logic [1:0]        walk_phase;
        logic [IDX_W-1:0]  symmetric_index;
        logic [IDX_W-1:0]  cyclic_index;
    } t_state;

    typedef struct packed {
        logic [1:0]         quadrant;
        logic [LEVEL_W-1:0] drive_level;
        logic [SQ_MAX-1:0]  square_bits;
    } t_result;

endpackage

### rtl/qwtg_cfg_regs.sv
module qwtg_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qwtg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qwtg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output qwtg_pkg::t_cfg                    o_cfg
);

    qwtg_pkg::t_cfg r_cfg;
    qwtg_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                qwtg_pkg::REG_WAVE_MODE:    n_cfg.wave_mode = i_cfg_data[0];
                qwtg_pkg::REG_TABLE_LENGTH: n_cfg.table_length =
                                                i_cfg_data[qwtg_pkg::LEN_W-1:0];
                qwtg_pkg::REG_TABLE_LOW:    n_cfg.table_words[63:0] = i_cfg_data;
                qwtg_pkg::REG_TABLE_HIGH:   n_cfg.table_words[127:64] = i_cfg_data;
                qwtg_pkg::REG_GAIN:         n_cfg.gain =
                                                i_cfg_data[qwtg_pkg::GAIN_W-1:0];
                qwtg_pkg::REG_CENTER:       n_cfg.center_offset =
                                                i_cfg_data[qwtg_pkg::LEVEL_W-1:0];
                qwtg_pkg::REG_SQ_PERIOD:    n_cfg.square_period =
                                                i_cfg_data[qwtg_pkg::TICK_W-1:0];
                qwtg_pkg::REG_SQ_THRESH:    n_cfg.square_thresholds = i_cfg_data[27:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_mode         <= qwtg_pkg::RST_WAVE_MODE;
            r_cfg.table_length      <= qwtg_pkg::RST_TABLE_LENGTH;
            r_cfg.table_words       <= {qwtg_pkg::RST_TABLE_HIGH, qwtg_pkg::RST_TABLE_LOW};
            r_cfg.gain              <= qwtg_pkg::RST_GAIN;
            r_cfg.center_offset     <= qwtg_pkg::RST_CENTER;
            r_cfg.square_period     <= qwtg_pkg::RST_SQ_PERIOD;
            r_cfg.square_thresholds <= qwtg_pkg::RST_SQ_THRESH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/qwtg_tick_calc.sv
module qwtg_tick_calc #(
    parameter int TABLE_DEPTH    = qwtg_pkg::TABLE_DEPTH_DEF,
    parameter int SQUARE_OUTPUTS = qwtg_pkg::SQUARE_OUTPUTS_DEF
) (
    input  qwtg_pkg::t_cfg    i_cfg,
    input  qwtg_pkg::t_state  i_state,
    input  logic              i_advance,
    output qwtg_pkg::t_state  o_state,
    output qwtg_pkg::t_result o_result
);

    localparam logic [qwtg_pkg::LEN_W-1:0] DEPTH_LEN = qwtg_pkg::LEN_W'(TABLE_DEPTH);

    logic [qwtg_pkg::LEN_W-1:0]   len_clip;
    logic [qwtg_pkg::LEN_W-1:0]   len_sym;
    logic [qwtg_pkg::LEN_W-1:0]   len_cyc;
    logic [qwtg_pkg::IDX_W-1:0]   rd_idx;
    logic [qwtg_pkg::AMP_W-1:0]   amp;
    logic [7:0]                   prod;
    logic signed [9:0]            sym_sum;
    logic [8:0]                   cyc_lvl;
    logic [qwtg_pkg::LEVEL_W-1:0] level;
    logic [qwtg_pkg::SQ_MAX-1:0]  bits;
    logic [qwtg_pkg::LEN_W-1:0]   cyc_next;
    logic [qwtg_pkg::TICK_W:0]    tick_next;

    always_comb begin
        len_clip = (i_cfg.table_length > DEPTH_LEN) ? DEPTH_LEN : i_cfg.table_length;
        len_sym  = (len_clip < 6'd2) ? 6'd2 : len_clip;
        len_cyc  = (len_clip == 6'd0) ? 6'd1 : len_clip;
    end

    // shared table read and gain multiply
    assign rd_idx = (i_cfg.wave_mode == qwtg_pkg::MODE_SYMMETRIC) ?
                    i_state.symmetric_index : i_state.cyclic_index;
    assign amp  = ({1'b0, rd_idx} >= DEPTH_LEN) ? '0 :
                  i_cfg.table_words[{rd_idx, 2'b00} +: qwtg_pkg::AMP_W];
    assign prod = 8'(i_cfg.gain) * 8'(amp);

    always_comb begin
        if (i_state.walk_phase[1])
            sym_sum = $signed({2'b00, i_cfg.center_offset}) - $signed({2'b00, prod});
        else
            sym_sum = $signed({2'b00, i_cfg.center_offset}) + $signed({2'b00, prod});
        cyc_lvl = {prod, 1'b0};

        if (i_cfg.wave_mode == qwtg_pkg::MODE_SYMMETRIC) begin
            if (sym_sum < 0)
                level = '0;
            else if (sym_sum > 10'sd255)
                level = 8'hFF;
            else
                level = sym_sum[7:0];
        end else begin
            level = cyc_lvl[8] ? 8'hFF : cyc_lvl[7:0];
        end
    end

    always_comb begin
        bits = '0;
        for (int k = 0; k < qwtg_pkg::SQ_MAX; k++) begin
            if (k < SQUARE_OUTPUTS &&
                i_state.tick_count < i_cfg.square_thresholds[7*k +: qwtg_pkg::TICK_W])
                bits[k] = 1'b1;
        end
    end

    assign o_result.square_bits = bits;
    assign o_result.drive_level = level;
    assign o_result.quadrant    = (i_cfg.wave_mode == qwtg_pkg::MODE_SYMMETRIC) ?
                                  i_state.walk_phase : 2'd0;

    assign cyc_next  = {1'b0, i_state.cyclic_index} + 6'd1;
    assign tick_next = {1'b0, i_state.tick_count} + 8'd1;

    always_comb begin
        o_state = i_state;
        if (i_advance) begin
            if (i_cfg.wave_mode == qwtg_pkg::MODE_SYMMETRIC) begin
                if (!i_state.walk_phase[0]) begin
                    // rising quarter: turn at the top entry
                    if ({1'b0, i_state.symmetric_index} >= len_sym - 6'd1) begin
                        o_state.walk_phase      = i_state.walk_phase + 2'd1;
                        o_state.symmetric_index = qwtg_pkg::IDX_W'(len_sym - 6'd2);
                    end else begin
                        o_state.symmetric_index = i_state.symmetric_index + 5'd1;
                    end
                end else begin
                    if (i_state.symmetric_index == '0) begin
                        o_state.walk_phase      = i_state.walk_phase + 2'd1;
                        o_state.symmetric_index = 5'd1;
                    end else begin
                        o_state.symmetric_index = i_state.symmetric_index - 5'd1;
                    end
                end
            end else begin
                o_state.cyclic_index = (cyc_next >= len_cyc) ? '0 : cyc_next[4:0];
            end

            o_state.tick_count = (tick_next >= {1'b0, i_cfg.square_period}) ?
                                 '0 : tick_next[qwtg_pkg::TICK_W-1:0];
        end
    end

endmodule

### rtl/quarter_wave_table_generator_core.sv
// Input transfer to m_axis: input register, tick logic, result register.
// Throughput: one tick per cycle while m_axis does not stall.
// While a result waits downstream, only an empty input register takes a tick.
// Reset (synchronous, i_rst_n low): pipeline empty, tick/walk state zero,
// configuration registers back to their default table and settings.
module quarter_wave_table_generator_core #(
    parameter int TABLE_DEPTH    = qwtg_pkg::TABLE_DEPTH_DEF,
    parameter int SQUARE_OUTPUTS = qwtg_pkg::SQUARE_OUTPUTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [0] advance
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [3:0] square_bits,
                                                              // [11:4] drive_level,
                                                              // [13:12] quadrant
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qwtg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qwtg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    qwtg_pkg::t_cfg    cfg;
    qwtg_pkg::t_state  r_state;
    qwtg_pkg::t_state  n_state;
    qwtg_pkg::t_result calc_result;
    qwtg_pkg::t_result r_result;

    logic r_in_valid;
    logic r_in_advance;
    logic r_out_valid;
    logic out_free;
    logic fire;

    qwtg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    qwtg_tick_calc #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .SQUARE_OUTPUTS (SQUARE_OUTPUTS)
    ) u_calc (
        .i_cfg     (cfg),
        .i_state   (r_state),
        .i_advance (r_in_advance),
        .o_state   (n_state),
        .o_result  (calc_result)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (s_axis_tready)
                r_in_valid <= s_axis_tvalid;
            if (out_free)
                r_out_valid <= r_in_valid;
            if (fire)
                r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid)
            r_in_advance <= s_axis_tdata[0];
        if (fire)
            r_result <= calc_result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_result};

endmodule
